### hdl/hsv_vibrance_saturation_pixel_top_defines.svh
// Assertion macros shared by the pixel pipeline.
`ifndef HSV_VIBRANCE_SATURATION_PIXEL_TOP_DEFINES_SVH
`define HSV_VIBRANCE_SATURATION_PIXEL_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define HSVSAT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define HSVSAT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/hsvsat_pkg.sv
`timescale 1ns / 1ps
package hsvsat_pkg;

    localparam int CHANNEL_BITS = 16;
    localparam logic [15:0] CH_MASK = 16'((32'd1 << CHANNEL_BITS) - 32'd1);

    localparam logic [15:0] ONE_Q13  = 16'd8192;
    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam logic [15:0] LOG_CORR = 16'd22715;
    localparam logic [15:0] POW_CORR = 16'd22263;
    localparam logic [19:0] HUE_SPAN = 20'd393216;

    localparam int DIV_STAGES  = 17;
    localparam int POST_STAGES = 13;
    localparam int POST_BASE   = 1 + DIV_STAGES;
    localparam int NSTAGES     = 1 + DIV_STAGES + POST_STAGES + 1;

    typedef enum logic {
        REG_GAMMA = 1'b0,
        REG_GAIN  = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        SEC_R_Y = 3'd0,
        SEC_Y_G = 3'd1,
        SEC_G_C = 3'd2,
        SEC_C_B = 3'd3,
        SEC_B_M = 3'd4,
        SEC_M_R = 3'd5
    } sector_t;

    typedef struct packed {
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        logic [15:0] mx;
        sector_t     base;
        logic        neg;
        logic        special;
    } side_t;

    typedef struct packed {
        side_t       side;
        logic [32:0] ns;
        logic [32:0] nh;
        logic [15:0] ds;
        logic [15:0] dh;
    } div_in_t;

    typedef struct packed {
        side_t       side;
        logic [16:0] qs;
        logic [16:0] qh;
    } div_out_t;

    typedef struct packed {
        side_t       side;
        logic [32:0] ns;
        logic [32:0] nh;
        logic [15:0] ds;
        logic [15:0] dh;
        logic [16:0] rs;
        logic [16:0] rh;
        logic [16:0] qs;
        logic [16:0] qh;
    } dstg_t;

    typedef struct packed {
        side_t       side;
        logic [16:0] qs;
        logic [16:0] qh;
        sector_t     sector;
        logic [15:0] f;
        logic [15:0] m;
        logic [4:0]  e;
        logic [31:0] mm;
        logic [31:0] tc;
        logic [20:0] negl;
        logic [36:0] mag;
        logic [15:0] y;
        logic [8:0]  sh;
        logic [31:0] yy;
        logic [31:0] c2;
        logic [16:0] pw;
        logic [32:0] spm;
        logic [16:0] sp;
        logic [31:0] vs;
        logic [31:0] fvs;
    } post_t;

    // One restoring division step: {new remainder, quotient bit}.
    function automatic logic [17:0] div_step(logic [16:0] r, logic nb, logic [15:0] d);
        logic [16:0] t;
        t = {r[15:0], nb};
        if (t >= {1'b0, d}) begin
            return {t - {1'b0, d}, 1'b1};
        end else begin
            return {t, 1'b0};
        end
    endfunction

endpackage

### hdl/hsvsat_div.sv
`timescale 1ns / 1ps
module hsvsat_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  hsvsat_pkg::div_in_t                 in_data,
    input  logic                                in_valid,
    input  logic [hsvsat_pkg::DIV_STAGES-1:0]   adv,
    output logic [hsvsat_pkg::DIV_STAGES-1:0]   stage_valid,
    output hsvsat_pkg::div_out_t                out_data
);
    import hsvsat_pkg::*;

    dstg_t                  st_reg  [DIV_STAGES];
    dstg_t                  st_next [DIV_STAGES];
    dstg_t                  src     [DIV_STAGES];
    logic [DIV_STAGES-1:0]  vld_reg;
    logic [DIV_STAGES-1:0]  vld_src;

    // Pick each stage's source: the input word for the first, the prior stage otherwise
    always_comb begin
        src[0].side = in_data.side;
        src[0].ns   = in_data.ns;
        src[0].nh   = in_data.nh;
        src[0].ds   = in_data.ds;
        src[0].dh   = in_data.dh;
        src[0].rs   = {1'b0, in_data.ns[32:17]};
        src[0].rh   = {1'b0, in_data.nh[32:17]};
        src[0].qs   = '0;
        src[0].qh   = '0;
        for (int j = 1; j < DIV_STAGES; j++) begin
            src[j] = st_reg[j-1];
        end
    end

    // Retire one quotient bit per stage for both divisions
    always_comb begin
        logic [17:0] ss;
        logic [17:0] hs;
        for (int j = 0; j < DIV_STAGES; j++) begin
            ss = div_step(src[j].rs, src[j].ns[DIV_STAGES-1-j], src[j].ds);
            hs = div_step(src[j].rh, src[j].nh[DIV_STAGES-1-j], src[j].dh);
            st_next[j]    = src[j];
            st_next[j].rs = ss[17:1];
            st_next[j].rh = hs[17:1];
            st_next[j].qs = {src[j].qs[15:0], ss[0]};
            st_next[j].qh = {src[j].qh[15:0], hs[0]};
        end
    end

    assign vld_src = {vld_reg[DIV_STAGES-2:0], in_valid};

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int j = 0; j < DIV_STAGES; j++) begin
                if (adv[j]) begin
                    vld_reg[j] <= vld_src[j];
                end
            end
        end
    end

    // Advance stage data
    always_ff @(posedge aclk) begin
        for (int j = 0; j < DIV_STAGES; j++) begin
            if (adv[j]) begin
                st_reg[j] <= st_next[j];
            end
        end
    end

    assign stage_valid   = vld_reg;
    assign out_data.side = st_reg[DIV_STAGES-1].side;
    assign out_data.qs   = st_reg[DIV_STAGES-1].qs;
    assign out_data.qh   = st_reg[DIV_STAGES-1].qh;

endmodule

### hdl/hsv_vibrance_saturation_pixel_top.sv
`timescale 1ns / 1ps
// Structure: 32 register stages from the accepted input word to m_valid: input,
// 17 divider steps, 13 post stages, output.
// Throughput: one pixel per clock while the output is not stalled; the two 17-stage restoring dividers
// (saturation and hue) and the log2/pow2 multiplier stages are fully pipelined.
// A stalled output only blocks stages that hold data; empty stages keep filling.
// Reset (aresetn low, synchronous) clears all valid bits and loads both
// configuration registers with 1.0.
module hsv_vibrance_saturation_pixel_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_red_in,
    input  logic [15:0] s_green_in,
    input  logic [15:0] s_blue_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_red_out,
    output logic [15:0] m_green_out,
    output logic [15:0] m_blue_out
);
    import hsvsat_pkg::*;

    `include "hsv_vibrance_saturation_pixel_top_defines.svh"

    logic [15:0] gamma_reg;
    logic [15:0] gain_reg;

    logic [NSTAGES-1:0]     vld;
    logic [NSTAGES-1:0]     adv;
    logic                   in_vld_reg;
    div_in_t                in_reg;
    div_in_t                in_next;
    logic [DIV_STAGES-1:0]  div_vld;
    div_out_t               div_out;
    logic [POST_STAGES-1:0] post_vld_reg;
    post_t                  post_reg [POST_STAGES];
    post_t                  pn       [POST_STAGES];
    logic                   out_vld_reg;
    logic [15:0]            red_reg, green_reg, blue_reg;
    logic [15:0]            red_next, green_next, blue_next;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gamma_reg <= ONE_Q13;
            gain_reg  <= ONE_Q13;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GAMMA: gamma_reg <= cfg_data;
                REG_GAIN:  gain_reg  <= cfg_data;
                default:   gamma_reg <= gamma_reg;
            endcase
        end
    end

    // Collect valid bits and ripple the advance enables back from the output
    assign vld = {out_vld_reg, post_vld_reg, div_vld, in_vld_reg};

    always_comb begin
        adv[NSTAGES-1] = !vld[NSTAGES-1] || m_ready;
        for (int i = NSTAGES - 2; i >= 0; i--) begin
            adv[i] = !vld[i] || adv[i+1];
        end
    end

    assign s_ready = adv[0];

    // Find max, min, hue base and the two dividends
    always_comb begin
        logic [15:0] r, g, b, mx, mn, delta, anum;
        logic [16:0] num;
        r  = s_red_in & CH_MASK;
        g  = s_green_in & CH_MASK;
        b  = s_blue_in & CH_MASK;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        in_next.side.r  = r;
        in_next.side.g  = g;
        in_next.side.b  = b;
        in_next.side.mx = mx;
        in_next.side.special = (mx == 16'd0) || (delta == 16'd0);
        if (r == mx) begin
            in_next.side.base = SEC_R_Y;
            num = {1'b0, g} - {1'b0, b};
        end else if (g == mx) begin
            in_next.side.base = SEC_G_C;
            num = {1'b0, b} - {1'b0, r};
        end else begin
            in_next.side.base = SEC_B_M;
            num = {1'b0, r} - {1'b0, g};
        end
        in_next.side.neg = num[16];
        anum = num[16] ? 16'(-num) : num[15:0];
        in_next.ns = {1'b0, delta, 16'd0};
        in_next.nh = num[16] ? ({1'b0, anum, 16'd0} + 33'(delta) - 33'd1)
                             : {1'b0, anum, 16'd0};
        in_next.ds = mx;
        in_next.dh = delta;
    end

    // Input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (adv[0]) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            in_reg <= in_next;
        end
    end

    hsvsat_div u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_data     (in_reg),
        .in_valid    (in_vld_reg),
        .adv         (adv[POST_BASE-1:1]),
        .stage_valid (div_vld),
        .out_data    (div_out)
    );

    // Hue, log2, power, gain and clamp stages, and the rebuild products
    always_comb begin
        logic [19:0] hraw;
        logic [32:0] sl;
        logic [15:0] t;
        logic [37:0] zsum;
        logic [23:0] zm;
        logic [16:0] mant;
        logic [19:0] spw;
        logic [32:0] vsw;
        logic [47:0] fw;

        // Hue wrap and log2 normalize
        pn[0]      = '0;
        pn[0].side = div_out.side;
        pn[0].qs   = div_out.qs;
        pn[0].qh   = div_out.qh;
        if (div_out.side.neg) begin
            hraw = {1'b0, div_out.side.base, 16'd0} + HUE_SPAN - 20'(div_out.qh);
            if (hraw >= HUE_SPAN) hraw = hraw - HUE_SPAN;
        end else begin
            hraw = {1'b0, div_out.side.base, 16'd0} + 20'(div_out.qh);
        end
        pn[0].sector = sector_t'(hraw[18:16]);
        pn[0].f      = hraw[15:0];
        pn[0].e      = 5'd16;
        for (int i = 0; i < 17; i++) begin
            if (div_out.qs[i]) pn[0].e = 5'(16 - i);
        end
        sl       = 33'(div_out.qs) << pn[0].e;
        pn[0].m  = sl[15:0];

        // Square the mantissa
        pn[1]    = post_reg[0];
        pn[1].mm = 32'(post_reg[0].m) * 32'(post_reg[0].m);

        // Log2 correction product
        pn[2]    = post_reg[1];
        t        = post_reg[1].m - post_reg[1].mm[31:16];
        pn[2].tc = 32'(t) * 32'(LOG_CORR);

        // Magnitude of log2
        pn[3]      = post_reg[2];
        pn[3].negl = 21'({post_reg[2].e, 16'd0})
                   - 21'({1'b0, post_reg[2].m} + {1'b0, post_reg[2].tc[31:16]});

        // Scale by the exponent
        pn[4]     = post_reg[3];
        pn[4].mag = 37'(post_reg[3].negl) * 37'(gamma_reg);

        // Round the exponent up and split it
        pn[5] = post_reg[4];
        zsum  = 38'(post_reg[4].mag) + 38'd8191;
        zm    = zsum[36:13];
        if (zm[15:0] == 16'd0) begin
            pn[5].sh = {1'b0, zm[23:16]};
            pn[5].y  = 16'd0;
        end else begin
            pn[5].sh = {1'b0, zm[23:16]} + 9'd1;
            pn[5].y  = 16'(ONE_Q16 - 17'(zm[15:0]));
        end

        // Square the fraction
        pn[6]    = post_reg[5];
        pn[6].yy = 32'(post_reg[5].y) * 32'(post_reg[5].y);

        // Pow2 correction product
        pn[7]    = post_reg[6];
        t        = post_reg[6].y - post_reg[6].yy[31:16];
        pn[7].c2 = 32'(t) * 32'(POW_CORR);

        // Shift the mantissa down
        pn[8] = post_reg[7];
        mant  = ONE_Q16 + 17'(post_reg[7].y) - 17'(post_reg[7].c2[31:16]);
        pn[8].pw = (post_reg[7].sh >= 9'd32) ? 17'd0 : (mant >> post_reg[7].sh[4:0]);

        // Apply the gain
        pn[9]     = post_reg[8];
        pn[9].spm = 33'(post_reg[8].pw) * 33'(gain_reg);

        // Clamp to 1.0
        pn[10]    = post_reg[9];
        spw       = post_reg[9].spm[32:13];
        pn[10].sp = (spw > 20'(ONE_Q16)) ? ONE_Q16 : spw[16:0];

        // Value times saturation
        pn[11]    = post_reg[10];
        vsw       = 33'(post_reg[10].side.mx) * 33'(post_reg[10].sp);
        pn[11].vs = vsw[31:0];

        // Fraction times VS
        pn[12]     = post_reg[11];
        fw         = 48'(post_reg[11].f) * 48'(post_reg[11].vs);
        pn[12].fvs = fw[47:16];
    end

    // Advance post-divider valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            post_vld_reg <= '0;
        end else begin
            for (int k = 0; k < POST_STAGES; k++) begin
                if (adv[POST_BASE+k]) begin
                    post_vld_reg[k] <= vld[POST_BASE+k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < POST_STAGES; k++) begin
            if (adv[POST_BASE+k]) begin
                post_reg[k] <= pn[k];
            end
        end
    end

    // Rebuild RGB by hue sector; bypass at unity gamma and gain; grey when saturation is zero
    always_comb begin
        post_t       lst;
        logic [31:0] vv, pp, qq, tt, ro, go, bo;
        lst = post_reg[POST_STAGES-1];
        vv  = {lst.side.mx, 16'd0};
        pp  = vv - lst.vs;
        qq  = vv - lst.fvs;
        tt  = pp + lst.fvs;
        case (lst.sector)
            SEC_R_Y: begin ro = vv; go = tt; bo = pp; end
            SEC_Y_G: begin ro = qq; go = vv; bo = pp; end
            SEC_G_C: begin ro = pp; go = vv; bo = tt; end
            SEC_C_B: begin ro = pp; go = qq; bo = vv; end
            SEC_B_M: begin ro = tt; go = pp; bo = vv; end
            default: begin ro = vv; go = pp; bo = qq; end
        endcase
        if (gamma_reg == ONE_Q13 && gain_reg == ONE_Q13) begin
            red_next   = lst.side.r;
            green_next = lst.side.g;
            blue_next  = lst.side.b;
        end else if (lst.side.special || lst.sp == 17'd0) begin
            red_next   = lst.side.mx;
            green_next = lst.side.mx;
            blue_next  = lst.side.mx;
        end else begin
            red_next   = ro[31:16];
            green_next = go[31:16];
            blue_next  = bo[31:16];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv[NSTAGES-1]) begin
            out_vld_reg <= vld[NSTAGES-2];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[NSTAGES-1]) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_valid     = out_vld_reg;
    assign m_red_out   = red_reg;
    assign m_green_out = green_reg;
    assign m_blue_out  = blue_reg;

    `HSVSAT_ASSERT_IMP(a_ready_when_drained, !out_vld_reg, s_ready, "input blocked with empty output")
    `HSVSAT_ASSERT_NEXT(a_accept_loads, s_valid && s_ready, in_vld_reg, "accepted word not captured")
    `HSVSAT_ASSERT_IMP(a_sat_clamped, post_vld_reg[10], post_reg[10].sp <= ONE_Q16, "saturation over 1.0")

endmodule
